[hdl/nearest_centroid_assign_assert.svh]
// assertion macros for the nearest centroid assignment block
// expects signals named clock and reset in the scope of each use
`ifndef NEAREST_CENTROID_ASSIGN_ASSERT_SVH
`define NEAREST_CENTROID_ASSIGN_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define NCA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define NCA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define NCA_ASSERT(lbl, prop, msg)
`define NCA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/nca_pkg.sv]
// shared types and constants of the nearest centroid assignment block
// no dependencies
package nca_pkg;

   localparam int COORD_W     = 16;
   localparam int LABEL_W     = 4;
   localparam int CFG_W       = 5;
   localparam int DIST_W      = 2 * COORD_W + 2;
   localparam int COUNT_W     = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int RANGE_W     = 9;

   typedef enum logic {
      FUNC_LOAD     = 1'b0,
      FUNC_CLASSIFY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ISSUE,
      BK_DRAIN
   } back_state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      func_type               func;
      logic [LABEL_W-1:0]     centroid_index;
      coord_type              coord_x;
      coord_type              coord_y;
      coord_type              coord_z;
      logic [LABEL_W-1:0]     prev_label;
      logic                   batch_first;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0]     nearest_cluster;
      logic [DIST_W-1:0]      min_distance;
      logic                   label_changed;
      logic [COUNT_W-1:0]     changed_total;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } sample_ctl_type;

endpackage

[hdl/nca_dist.sv]
// centroid store and pipelined squared-distance unit
// depends on nca_pkg
module nca_dist #(
   parameter int MAX_CLUSTERS = 16,
   parameter int IDX_W        = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  nca_pkg::point_type      wr_point,
   input  nca_pkg::sample_ctl_type rd_ctl,
   input  logic [IDX_W-1:0]        rd_addr,
   input  nca_pkg::point_type      point,
   output nca_pkg::sample_ctl_type smp_ctl,
   output logic [nca_pkg::DIST_W-1:0] smp_dist
);
   import nca_pkg::*;

   localparam int SQ_W = 2 * COORD_W;

   point_type             table_mem [MAX_CLUSTERS];
   point_type             cent_ff;
   sample_ctl_type        ctl0_ff, ctl1_ff, ctl2_ff, ctl3_ff;
   logic [COORD_W-1:0]    mag_x_in, mag_y_in, mag_z_in;
   logic [COORD_W-1:0]    mag_x_ff, mag_y_ff, mag_z_ff;
   logic [SQ_W-1:0]       sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_W-1:0]     sum_ff;

   function automatic logic [COORD_W-1:0] abs_diff(input coord_type a, input coord_type b);
      logic [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
   endfunction

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_point;
      end
      cent_ff <= table_mem[rd_addr];
   end

   always_comb begin
      mag_x_in = abs_diff(point.x, cent_ff.x);
      mag_y_in = abs_diff(point.y, cent_ff.y);
      mag_z_in = abs_diff(point.z, cent_ff.z);
   end

   // read, difference, square, sum
   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      sq_x_ff  <= mag_x_ff * mag_x_ff;
      sq_y_ff  <= mag_y_ff * mag_y_ff;
      sq_z_ff  <= mag_z_ff * mag_z_ff;
      sum_ff   <= DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff) + DIST_W'(sq_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl0_ff <= rd_ctl;
         ctl1_ff <= ctl0_ff;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   assign smp_ctl  = ctl3_ff;
   assign smp_dist = sum_ff;

endmodule

[hdl/nca_front.sv]
// front end: takes request beats, drops out-of-table loads, queues the rest
// depends on nca_pkg and nearest_centroid_assign_assert.svh
`include "nearest_centroid_assign_assert.svh"
module nca_front #(
   parameter int MAX_CLUSTERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nca_pkg::req_type req_data,
   output logic             q_valid,
   output nca_pkg::req_type q_data,
   input  logic             q_pop
);
   import nca_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             full;
   logic             in_range;
   logic             push;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign busy     = full | reset;
   assign in_range = (RANGE_W'(req_data.centroid_index) < RANGE_W'(MAX_CLUSTERS));
   // loads past the table end are taken and dropped here
   assign push     = start && !busy && (req_data.func == FUNC_CLASSIFY || in_range);
   assign q_valid  = (count_ff != '0);
   assign q_data   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + PTR_W'(1));
         end
         if (q_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + PTR_W'(1));
         end
         count_ff <= CNT_W'(count_ff + CNT_W'(push) - CNT_W'(q_pop));
      end
   end

   `NCA_ASSERT(a_q_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `NCA_ASSERT(a_q_pop_nonempty, q_pop |-> count_ff != '0, "pop from empty queue")
   `NCA_ASSERT(a_q_fill, (push && !q_pop) |=> count_ff == $past(count_ff) + CNT_W'(1), "push lost")

endmodule

[hdl/nca_back.sv]
// back end: sequences loads and nearest searches, keeps the changed count
// depends on nca_pkg and nearest_centroid_assign_assert.svh
`include "nearest_centroid_assign_assert.svh"
module nca_back #(
   parameter int MAX_CLUSTERS = 16,
   parameter int IDX_W        = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [nca_pkg::CFG_W-1:0] cluster_count,
   input  logic                    q_valid,
   input  nca_pkg::req_type        q_data,
   output logic                    q_pop,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output nca_pkg::point_type      wr_point,
   output nca_pkg::sample_ctl_type rd_ctl,
   output logic [IDX_W-1:0]        rd_addr,
   output nca_pkg::point_type      point,
   input  nca_pkg::sample_ctl_type smp_ctl,
   input  logic [nca_pkg::DIST_W-1:0] smp_dist,
   output logic                    rsp_strobe,
   output nca_pkg::rsp_type        rsp_data
);
   import nca_pkg::*;

   localparam int LIMIT = (MAX_CLUSTERS < 2 ** CFG_W - 1) ? MAX_CLUSTERS : 2 ** CFG_W - 1;

   back_state_type       state_ff, state_in;
   logic [CFG_W-1:0]     issue_idx_ff;
   point_type            point_ff;
   logic [LABEL_W-1:0]   prev_ff;
   logic                 first_ff;
   logic [DIST_W-1:0]    best_d_ff;
   logic [CFG_W-1:0]     best_idx_ff;
   logic [CFG_W-1:0]     seen_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff;

   logic [CFG_W-1:0]     n_used;
   logic                 last_issue;
   logic                 load_point;
   logic [CFG_W-1:0]     smp_idx;
   logic                 take;
   logic [DIST_W-1:0]    cand_d;
   logic [CFG_W-1:0]     cand_idx;
   logic                 changed;
   logic [COUNT_W-1:0]   count_base;

   // search length: zero counts as one, capped at the table size
   always_comb begin
      if (cluster_count == '0) begin
         n_used = CFG_W'(1);
      end else if (cluster_count > CFG_W'(LIMIT)) begin
         n_used = CFG_W'(LIMIT);
      end else begin
         n_used = cluster_count;
      end
   end

   assign last_issue = (issue_idx_ff == CFG_W'(n_used - CFG_W'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_data.func == FUNC_CLASSIFY) begin
               state_in = BK_ISSUE;
            end
         end
         BK_ISSUE: begin
            if (last_issue) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (smp_ctl.valid && smp_ctl.last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      load_point = 1'b0;
      rd_ctl     = '0;
      strobe_in  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop      = q_valid;
            wr_en      = q_valid && (q_data.func == FUNC_LOAD);
            load_point = q_valid && (q_data.func == FUNC_CLASSIFY);
         end
         BK_ISSUE: begin
            rd_ctl.valid = 1'b1;
            rd_ctl.first = (issue_idx_ff == '0);
            rd_ctl.last  = last_issue;
         end
         BK_DRAIN: begin
            strobe_in = smp_ctl.valid && smp_ctl.last;
         end
         default: begin
         end
      endcase
   end

   assign wr_addr  = IDX_W'(q_data.centroid_index);
   assign wr_point = '{x: q_data.coord_x, y: q_data.coord_y, z: q_data.coord_z};
   assign rd_addr  = IDX_W'(issue_idx_ff);
   assign point    = point_ff;

   // running minimum, strict compare keeps the lowest index on ties
   always_comb begin
      smp_idx    = smp_ctl.first ? '0 : seen_ff;
      take       = smp_ctl.first || (smp_dist < best_d_ff);
      cand_d     = take ? smp_dist : best_d_ff;
      cand_idx   = take ? smp_idx : best_idx_ff;
      changed    = (cand_idx != CFG_W'(prev_ff));
      count_base = first_ff ? '0 : count_ff;
      count_in   = (changed && count_base != '1) ? COUNT_W'(count_base + COUNT_W'(1))
                                                 : count_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (strobe_in) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_point) begin
         point_ff     <= '{x: q_data.coord_x, y: q_data.coord_y, z: q_data.coord_z};
         prev_ff      <= q_data.prev_label;
         first_ff     <= q_data.batch_first;
         issue_idx_ff <= '0;
      end else if (state_ff == BK_ISSUE) begin
         issue_idx_ff <= CFG_W'(issue_idx_ff + CFG_W'(1));
      end
      if (smp_ctl.valid) begin
         best_d_ff   <= cand_d;
         best_idx_ff <= cand_idx;
         seen_ff     <= CFG_W'(smp_idx + CFG_W'(1));
      end
      if (strobe_in) begin
         rsp_ff.nearest_cluster <= LABEL_W'(cand_idx);
         rsp_ff.min_distance    <= cand_d;
         rsp_ff.label_changed   <= changed;
         rsp_ff.changed_total   <= count_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `NCA_ASSERT(a_rsp_after_drain, strobe_ff |-> $past(state_ff) == BK_DRAIN, "stray result")
   `NCA_ASSERT(a_smp_in_search, smp_ctl.valid |-> (state_ff == BK_ISSUE || state_ff == BK_DRAIN), "sample outside search")
   `NCA_ASSERT(a_count_holds, (state_ff != BK_DRAIN) |=> $stable(count_ff), "count moved outside a result")

endmodule

[hdl/nearest_centroid_assign.sv]
// k-means assignment: load beat queued, then written to the table when the sequencer pops it, no result
// classify beat: one result strobe after a sweep of n centroids, n = clamped cluster_count;
// one classify searched at a time, through the one-centroid-per-cycle distance pipeline
// a two-beat queue lets start be taken while a search runs; the receiver cannot stall
// synchronous reset: queue and sequencer idle, cluster_count 1, changed count 0,
// centroid table left undefined until loaded
module nearest_centroid_assign #(
   parameter int MAX_CLUSTERS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  nca_pkg::req_type           req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [nca_pkg::CFG_W-1:0]  csr_data,
   output logic                       rsp_strobe,
   output nca_pkg::rsp_type           rsp_data
);
   import nca_pkg::*;

   // table address width, at least one bit
   localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

   logic [CFG_W-1:0] cluster_count_ff;

   // queue between front and back
   logic             q_valid;
   req_type          q_data;
   logic             q_pop;

   // back to distance unit
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   point_type        wr_point;
   sample_ctl_type   rd_ctl;
   logic [IDX_W-1:0] rd_addr;
   point_type        point;

   // distance unit back to sequencer
   sample_ctl_type   smp_ctl;
   logic [DIST_W-1:0] smp_dist;

   // csr beat: the one register, held off only during reset
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff <= CFG_W'(1);
      end else if (csr_valid && csr_ready) begin
         cluster_count_ff <= csr_data;
      end
   end

   // front: accept, drop out-of-table loads, queue
   nca_front #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop)
   );

   // back: table writes, centroid sweep, running minimum, changed count
   nca_back #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .IDX_W        (IDX_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cluster_count (cluster_count_ff),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_point      (wr_point),
      .rd_ctl        (rd_ctl),
      .rd_addr       (rd_addr),
      .point         (point),
      .smp_ctl       (smp_ctl),
      .smp_dist      (smp_dist),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data)
   );

   // centroid store plus read / difference / square / sum pipeline
   nca_dist #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .IDX_W        (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_point (wr_point),
      .rd_ctl   (rd_ctl),
      .rd_addr  (rd_addr),
      .point    (point),
      .smp_ctl  (smp_ctl),
      .smp_dist (smp_dist)
   );

endmodule

[sim/tb.sv]
// testbench for nearest_centroid_assign: centroid loads, point classification, changed count
// depends on nca_pkg and the nearest_centroid_assign rtl; results checked against a local predictor
module tb;
   import nca_pkg::*;

   localparam int        TABLE_DEPTH   = 16;
   localparam int        SEARCH_SETTLE = 24;      // longer than the longest search
   localparam int        DRAIN_GUARD   = 10000;
   localparam int        CHANGE_RUN    = 64;
   localparam coord_type COORD_MAX     = 16'sh7FFF;
   localparam coord_type COORD_MIN     = 16'sh8000;

   // how random coordinates are spread
   typedef enum bit {
      SPREAD_FULL,
      SPREAD_TIGHT
   } spread_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // command side
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;

   // cluster count register port
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   // result side
   logic    rsp_strobe;
   rsp_type rsp_data;

   // predictor state: centroid table, cluster count, changed tally
   coord_type          cent_x [TABLE_DEPTH];
   coord_type          cent_y [TABLE_DEPTH];
   coord_type          cent_z [TABLE_DEPTH];
   logic [CFG_W-1:0]   cluster_setting = 5'd1;
   logic [COUNT_W-1:0] changed_tally   = '0;

   // assignments still owed by the block, oldest first
   rsp_type expected_results [$];
   int      mismatch_count = 0;

   nearest_centroid_assign u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // zero searches one entry, anything past the table searches all of it
   function automatic int searched_entries();
      if (cluster_setting == 0) return 1;
      if (cluster_setting > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(cluster_setting);
   endfunction

   // exact squared distance, strict compare so the lowest index wins a tie
   function automatic void find_nearest(input  coord_type          px,
                                        input  coord_type          py,
                                        input  coord_type          pz,
                                        output logic [LABEL_W-1:0] best,
                                        output logic [DIST_W-1:0]  best_dist);
      longint dx, dy, dz, d, lowest;
      int     n;
      n      = searched_entries();
      best   = '0;
      lowest = 0;
      for (int j = 0; j < n; j++) begin
         dx = longint'(px) - longint'(cent_x[j]);
         dy = longint'(py) - longint'(cent_y[j]);
         dz = longint'(pz) - longint'(cent_z[j]);
         d  = dx * dx + dy * dy + dz * dz;
         if (j == 0 || d < lowest) begin
            lowest = d;
            best   = LABEL_W'(j);
         end
      end
      best_dist = lowest[DIST_W-1:0];
   endfunction

   // applies one accepted beat to the predictor, queues the assignment it owes
   function automatic void predict_assignment(input req_type beat);
      rsp_type            owed;
      logic [LABEL_W-1:0] label;
      logic [DIST_W-1:0]  near_dist;
      logic               changed;
      if (beat.func == FUNC_LOAD) begin
         // label and batch fields of a load mean nothing
         cent_x[beat.centroid_index] = beat.coord_x;
         cent_y[beat.centroid_index] = beat.coord_y;
         cent_z[beat.centroid_index] = beat.coord_z;
         return;
      end
      if (beat.batch_first) changed_tally = '0;
      find_nearest(beat.coord_x, beat.coord_y, beat.coord_z, label, near_dist);
      changed = (label != beat.prev_label);
      // tally holds at its ceiling
      if (changed && changed_tally != '1) changed_tally = changed_tally + 1'b1;
      owed.nearest_cluster = label;
      owed.min_distance    = near_dist;
      owed.label_changed   = changed;
      owed.changed_total   = changed_tally;
      expected_results.push_back(owed);
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // the block cannot be held off, so every strobed cycle is a result beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no assignment owed: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("nearest_cluster", want.nearest_cluster, rsp_data.nearest_cluster);
            check_field("min_distance", want.min_distance, rsp_data.min_distance);
            check_field("label_changed", want.label_changed, rsp_data.label_changed);
            check_field("changed_total", want.changed_total, rsp_data.changed_total);
         end
      end
   end

   // ------------------------------------------------------------------
   // driving; every task returns just after a rising edge
   // ------------------------------------------------------------------

   function automatic req_type make_beat(input func_type  f,
                                         input int        entry,
                                         input coord_type x,
                                         input coord_type y,
                                         input coord_type z,
                                         input int        prev,
                                         input bit        first);
      req_type beat;
      beat.func           = f;
      beat.centroid_index = LABEL_W'(entry);
      beat.coord_x        = x;
      beat.coord_y        = y;
      beat.coord_z        = z;
      beat.prev_label     = LABEL_W'(prev);
      beat.batch_first    = first;
      return beat;
   endfunction

   // start stays high on return so back-to-back beats need no second assignment
   task automatic send_beat(input req_type beat);
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      predict_assignment(beat);
   endtask

   // sender gap
   task automatic rest(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait for every owed result, then let a trailing load reach the table
   task automatic drain_block();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (expected_results.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SEARCH_SETTLE) @(posedge clock);
   endtask

   // register writes only while the block is idle
   task automatic write_cluster_count(input logic [CFG_W-1:0] setting);
      drain_block();
      csr_valid <= 1'b1;
      csr_data  <= setting;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid       <= 1'b0;
      cluster_setting  = setting;
   endtask

   // ------------------------------------------------------------------
   // random stimulus
   // ------------------------------------------------------------------

   function automatic coord_type clamp_coord(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   function automatic coord_type random_coord(input spread_type spread);
      // tight spread lands many points on equal distances
      if (spread == SPREAD_TIGHT) return clamp_coord(longint'($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         1:       return clamp_coord(longint'($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic req_type random_beat(input spread_type spread);
      req_type            beat;
      int                 src;
      logic [LABEL_W-1:0] label;
      logic [DIST_W-1:0]  near_dist;
      // index on a classify and label/batch on a load are noise
      beat.centroid_index = LABEL_W'($urandom_range(0, TABLE_DEPTH - 1));
      beat.prev_label     = LABEL_W'($urandom_range(0, TABLE_DEPTH - 1));
      beat.batch_first    = ($urandom_range(0, 15) == 0);
      beat.coord_x        = random_coord(spread);
      beat.coord_y        = random_coord(spread);
      beat.coord_z        = random_coord(spread);
      if ($urandom_range(0, 3) == 0) begin
         beat.func = FUNC_LOAD;
         // copy another entry now and then for exact duplicate ties
         if ($urandom_range(0, 7) == 0) begin
            src          = $urandom_range(0, TABLE_DEPTH - 1);
            beat.coord_x = cent_x[src];
            beat.coord_y = cent_y[src];
            beat.coord_z = cent_z[src];
         end
         return beat;
      end
      beat.func = FUNC_CLASSIFY;
      // points close to a searched centroid give close races
      if ($urandom_range(0, 4) < 2) begin
         src          = $urandom_range(0, searched_entries() - 1);
         beat.coord_x = clamp_coord(longint'(cent_x[src]) + longint'($urandom_range(0, 16)) - 8);
         beat.coord_y = clamp_coord(longint'(cent_y[src]) + longint'($urandom_range(0, 16)) - 8);
         beat.coord_z = clamp_coord(longint'(cent_z[src]) + longint'($urandom_range(0, 16)) - 8);
      end
      // half the points keep their label so the changed flag goes both ways
      if ($urandom_range(0, 1)) begin
         find_nearest(beat.coord_x, beat.coord_y, beat.coord_z, label, near_dist);
         beat.prev_label = label;
      end
      return beat;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // fill the whole table, then classify at the reset cluster count
   task automatic test_reset_defaults();
      coord_type cx, cy, cz;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (i)
            0: begin
               cx = COORD_MIN; cy = COORD_MIN; cz = COORD_MIN;
            end
            1: begin
               cx = COORD_MAX; cy = COORD_MAX; cz = COORD_MAX;
            end
            2, 3: begin
               cx = 100; cy = 100; cz = 100;
            end
            4: begin
               cx = 10; cy = 0; cz = 0;
            end
            5: begin
               cx = -10; cy = 0; cz = 0;
            end
            default: begin
               cx = coord_type'(i * 2000);
               cy = coord_type'(-i * 1500);
               cz = coord_type'(i * 700);
            end
         endcase
         // label and batch set on loads, must not touch the count
         send_beat(make_beat(FUNC_LOAD, i, cx, cy, cz, 15, 1'b1));
      end
      // only entry 0 searched: farthest possible distance
      send_beat(make_beat(FUNC_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 3, 1'b1));
   endtask

   // zero, above-table and full-table settings
   task automatic test_cluster_count_settings();
      write_cluster_count(5'd0);
      send_beat(make_beat(FUNC_CLASSIFY, 9, 0, 0, 0, 0, 1'b0));
      write_cluster_count(5'd31);
      send_beat(make_beat(FUNC_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1'b0));
      send_beat(make_beat(FUNC_CLASSIFY, 15, COORD_MIN, COORD_MAX, COORD_MIN, 15, 1'b0));
      write_cluster_count(5'd17);
      send_beat(make_beat(FUNC_CLASSIFY, 0, 29000, -21000, 9800, 14, 1'b0));
      write_cluster_count(5'd16);
      send_beat(make_beat(FUNC_CLASSIFY, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 1'b0));
   endtask

   // equal distances go to the lower entry
   task automatic test_tie_break();
      send_beat(make_beat(FUNC_CLASSIFY, 0, 0, 0, 0, 5, 1'b0));
      send_beat(make_beat(FUNC_CLASSIFY, 0, 100, 100, 100, 3, 1'b0));
   endtask

   // load fields ignored, classify right behind a load of the entry it hits
   task automatic test_load_then_classify();
      send_beat(make_beat(FUNC_LOAD, 7, 1, 2, 3, 15, 1'b1));
      send_beat(make_beat(FUNC_CLASSIFY, 2, 1, 2, 3, 0, 1'b0));
      send_beat(make_beat(FUNC_CLASSIFY, 0, 1, 2, 3, 7, 1'b1));
      send_beat(make_beat(FUNC_CLASSIFY, 0, 1, 2, 3, 6, 1'b0));
   endtask

   // phases of mixed traffic across cluster counts, gaps in most phases
   task automatic test_random_traffic();
      logic [CFG_W-1:0] setting;
      spread_type       spread;
      bit               idling;
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0:       setting = 5'd1;
            1:       setting = 5'd16;
            2:       setting = 5'd0;
            3:       setting = 5'd31;
            4:       setting = 5'd17;
            default: setting = CFG_W'($urandom_range(0, 31));
         endcase
         spread = (phase % 3 == 1) ? SPREAD_TIGHT : SPREAD_FULL;
         // one stretch mid run and the tail run without gaps
         idling = (phase != 6) && (phase != 10);
         write_cluster_count(setting);
         for (int k = 0; k < 150; k++) begin
            if (idling && $urandom_range(0, 3) == 0) rest($urandom_range(1, 16));
            send_beat(random_beat(spread));
         end
      end
   endtask

   // a run of changed points at the fastest search rate, then a new batch
   task automatic test_changed_count();
      write_cluster_count(5'd1);
      for (int k = 0; k < CHANGE_RUN; k++)
         send_beat(make_beat(FUNC_CLASSIFY, 0, random_coord(SPREAD_FULL),
                             random_coord(SPREAD_FULL), random_coord(SPREAD_FULL),
                             $urandom_range(1, 15), k == 0));
      // unchanged point, then a new batch
      send_beat(make_beat(FUNC_CLASSIFY, 0, 0, 0, 0, 0, 1'b0));
      send_beat(make_beat(FUNC_CLASSIFY, 0, 0, 0, 0, 5, 1'b1));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_cluster_count_settings();
      test_tie_break();
      test_load_then_classify();
      test_random_traffic();
      test_changed_count();

      drain_block();
      if (expected_results.size() != 0) begin
         $error("%0d assignments never came back", expected_results.size());
         mismatch_count += expected_results.size();
      end
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #25_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
